FILE: src/fpba_pkg.sv
// Shared types and constants for the fit-policy block allocator.
`default_nettype none

package fpba_pkg;

    // Default sizing of the free-size table
    localparam int MAX_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // Fixed port field widths
    localparam int SLOT_W       = 4;
    localparam int SIZE_W       = 16;
    localparam int IN_TDATA_W   = 24;  // slot + size, padded to bytes
    localparam int OUT_TDATA_W  = 24;  // chosen block + remaining size, padded
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 5;
    localparam int POLICY_W     = 2;
    localparam int BLK_USE_W    = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

    // Fit policy codes (code 3 refuses every request)
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd2;

    // Reset values of the configuration registers
    localparam logic [POLICY_W-1:0]  POLICY_RST  = POL_FIRST;
    localparam logic [BLK_USE_W-1:0] BLK_USE_RST = 5'd16;

    // Input item kind carried on tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_REQ  = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load_wr;    // write a loaded free size into the table
        logic start_req;  // latch request size, restart the scan
        logic scan_rd;    // read the table entry at the scan index
        logic commit;     // write back the granted block, load the result
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;   // scan index is the last block in use
        logic limit_zero;  // no block in use
        logic out_busy;    // result register holds an untaken result
    } t_dp_status;

endpackage

`default_nettype wire

FILE: src/fpba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: src/fpba_ctrl.sv
// Controller state machine: sequences loads, request scans and result commit.
`default_nettype none

module fpba_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_cmd,
    input  wire fpba_pkg::t_dp_status  i_status,
    output logic                       o_in_ready,
    output fpba_pkg::t_ctrl_cmd        o_cmd
);

    fpba_pkg::t_state r_state;
    fpba_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpba_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fpba_pkg::ST_IDLE: begin
                if (i_in_valid && i_in_cmd == fpba_pkg::CMD_REQ) begin
                    n_state = i_status.limit_zero ? fpba_pkg::ST_FINISH : fpba_pkg::ST_SCAN;
                end
            end
            fpba_pkg::ST_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = fpba_pkg::ST_DRAIN;
                end
            end
            fpba_pkg::ST_DRAIN: begin
                n_state = fpba_pkg::ST_FINISH;
            end
            fpba_pkg::ST_FINISH: begin
                if (!i_status.out_busy) begin
                    n_state = fpba_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fpba_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            fpba_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_wr   = i_in_valid && i_in_cmd == fpba_pkg::CMD_LOAD;
                o_cmd.start_req = i_in_valid && i_in_cmd == fpba_pkg::CMD_REQ;
            end
            fpba_pkg::ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
            end
            fpba_pkg::ST_DRAIN: begin
                o_cmd = '0;
            end
            fpba_pkg::ST_FINISH: begin
                o_cmd.commit = !i_status.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/fpba_dp.sv
// Datapath: config registers, free-size table, scan compare and result register.
`default_nettype none

module fpba_dp #(
    parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [fpba_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  wire logic [fpba_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic [fpba_pkg::IN_TDATA_W-1:0]    i_in_data,
    input  wire fpba_pkg::t_ctrl_cmd                i_cmd,
    input  wire logic                               i_out_ready,
    output fpba_pkg::t_dp_status                    o_status,
    output logic                                    o_out_valid,
    output logic                                    o_out_user,
    output logic [fpba_pkg::OUT_TDATA_W-1:0]        o_out_data
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (CNT_W > fpba_pkg::BLK_USE_W) ? CNT_W : fpba_pkg::BLK_USE_W;
    localparam int PAD_W = fpba_pkg::OUT_TDATA_W - fpba_pkg::SLOT_W - fpba_pkg::SIZE_W;

    logic [fpba_pkg::POLICY_W-1:0]  r_fit_policy;
    logic [fpba_pkg::BLK_USE_W-1:0] r_blocks_in_use;

    logic [SIZE_BITS-1:0] r_size;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_found;
    logic [IDX_W-1:0]     r_pick;
    logic [SIZE_BITS-1:0] r_best;

    logic                 r_out_vld;
    logic                 r_out_user;
    logic [fpba_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic [fpba_pkg::SLOT_W-1:0] in_slot;
    logic [SIZE_BITS-1:0]        in_size;
    logic [CMP_W-1:0]            lim;
    logic                        slot_ok;
    logic [SIZE_BITS-1:0]        rd_data;
    logic [SIZE_BITS-1:0]        remain;
    logic                        qual;
    logic                        take;
    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [SIZE_BITS-1:0]        ram_wdata;

    // Input field split and size cut to table width
    assign in_slot = i_in_data[fpba_pkg::SLOT_W-1:0];
    assign in_size = SIZE_BITS'(i_in_data[fpba_pkg::SLOT_W +: fpba_pkg::SIZE_W]);
    assign slot_ok = CMP_W'(in_slot) < CMP_W'(MAX_BLOCKS);

    // Blocks in use saturated to the table depth
    assign lim = (CMP_W'(r_blocks_in_use) > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS)
                                                                : CMP_W'(r_blocks_in_use);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_policy    <= fpba_pkg::POLICY_RST;
            r_blocks_in_use <= fpba_pkg::BLK_USE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                fpba_pkg::CFG_FIT_POLICY: begin
                    r_fit_policy <= i_cfg_data[fpba_pkg::POLICY_W-1:0];
                end
                fpba_pkg::CFG_BLOCKS_IN_USE: begin
                    r_blocks_in_use <= i_cfg_data[fpba_pkg::BLK_USE_W-1:0];
                end
                default: begin
                    r_fit_policy <= r_fit_policy;
                end
            endcase
        end
    end

    // Table write port: loads, and write-back of the granted block
    assign remain    = r_best - r_size;
    assign ram_we    = (i_cmd.load_wr && slot_ok) || (i_cmd.commit && r_found);
    assign ram_waddr = i_cmd.load_wr ? IDX_W'(in_slot) : r_pick;
    assign ram_wdata = i_cmd.load_wr ? in_size : remain;

    fpba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    // Scan index and read tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_req) begin
            r_size <= in_size;
            r_idx  <= '0;
        end else if (i_cmd.scan_rd) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        r_cmp_idx <= r_idx;
    end

    // Candidate selection by policy; ties keep the lower index
    assign qual = rd_data >= r_size;
    always_comb begin
        case (r_fit_policy)
            fpba_pkg::POL_WORST: take = qual && (!r_found || rd_data > r_best);
            fpba_pkg::POL_BEST:  take = qual && (!r_found || rd_data < r_best);
            fpba_pkg::POL_FIRST: take = qual && !r_found;
            default:             take = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_req) begin
            r_found <= 1'b0;
        end else if (r_cmp_vld && take) begin
            r_found <= 1'b1;
            r_pick  <= r_cmp_idx;
            r_best  <= rd_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_user <= r_found;
            if (r_found) begin
                r_out_data <= {PAD_W'(0), fpba_pkg::SIZE_W'(remain),
                               fpba_pkg::SLOT_W'(r_pick)};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_user  = r_out_user;
    assign o_out_data  = r_out_data;

    // Status to the controller
    assign o_status.scan_last  = (CMP_W'(r_idx) + CMP_W'(1)) == lim;
    assign o_status.limit_zero = lim == '0;
    assign o_status.out_busy   = r_out_vld && !i_out_ready;

endmodule

`default_nettype wire

FILE: src/fit_policy_block_allocator.sv
// Top level of the fit-policy block allocator: controller plus datapath.
// Load item: accepted back to back, gives no result.
// Request item: scans the blocks in use (capped at MAX_BLOCKS) in SCAN, then passes
// DRAIN and FINISH, where the result is registered; no new item is taken before that;
// with no block in use the scan and DRAIN are skipped and FINISH follows IDLE.
// One table entry is scanned per cycle; a waiting result only delays the next finish.
// Reset clears control state, the result valid flag and config; table contents are kept.
`default_nettype none

module fit_policy_block_allocator #(
    parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [fpba_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire logic [fpba_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [fpba_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,  // block_slot, size_value
    input  wire logic                             i_s_axis_tuser,  // command
    // result stream
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic [fpba_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,  // chosen_block, remaining_size
    output logic                                  o_m_axis_tuser   // granted
);

    fpba_pkg::t_ctrl_cmd  cmd;
    fpba_pkg::t_dp_status status;

    fpba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_cmd   (i_s_axis_tuser),
        .i_status   (status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    fpba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_axis_tdata),
        .i_cmd       (cmd),
        .i_out_ready (i_m_axis_tready),
        .o_status    (status),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_user  (o_m_axis_tuser),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: src/fpba_chk.sv
// Port-level checker for the fit-policy block allocator, bound to the top level.
`default_nettype none

module fpba_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_s_axis_tvalid,
    input wire logic                             o_s_axis_tready,
    input wire logic                             i_s_axis_tuser,
    input wire logic                             o_m_axis_tvalid,
    input wire logic                             i_m_axis_tready,
    input wire logic [fpba_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic                             o_m_axis_tuser
);

    logic in_xfer;
    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // No result is offered right after reset
    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // A request occupies the block: no transfer in the next cycle
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_s_axis_tuser == fpba_pkg::CMD_REQ |=> !o_s_axis_tready)
        else $error("input ready right after a request");

    // A load never creates a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_s_axis_tuser == fpba_pkg::CMD_LOAD && !o_m_axis_tvalid |=>
            !o_m_axis_tvalid)
        else $error("result after a load");

    // A refusal carries zero block and size
    a_refuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("refusal with nonzero fields");

endmodule

bind fit_policy_block_allocator fpba_chk u_fpba_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
